FILE: hdl/video_register_port_vram_access_macros.svh
// Assertion macros shared by the register port RTL.
`ifndef VIDEO_REGISTER_PORT_VRAM_ACCESS_MACROS_SVH
`define VIDEO_REGISTER_PORT_VRAM_ACCESS_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define VRPVA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define VRPVA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/vrpva_pkg.sv
// Shared types, constants and address helpers of the video register port.
package vrpva_pkg;

	localparam int NAME_TABLE_BYTES = 2048;
	localparam int PALETTE_ENTRIES  = 32;
	localparam int DATA_W           = 8;
	localparam int NT_IDX_W         = 11;
	localparam int PAL_IDX_W        = 5;

	typedef enum logic [1:0] {
		REQ_REG_READ  = 2'd0,
		REQ_REG_WRITE = 2'd1,
		REQ_DATA_READ = 2'd2,
		REQ_TICK      = 2'd3
	} req_t;

	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_STATUS = 3'd2;
	localparam logic [2:0] REG_SCROLL = 3'd5;
	localparam logic [2:0] REG_ADDR   = 3'd6;
	localparam logic [2:0] REG_DATA   = 3'd7;

	localparam logic CFG_MIRROR = 1'b0;

	localparam logic [7:0]  STATUS_RESET = 8'hA0;
	localparam logic [15:0] PTR_RESET    = 16'h2000;
	localparam logic [15:0] PTR_STEP_ROW = 16'd32;
	localparam logic [15:0] PTR_STEP_ONE = 16'd1;

	localparam logic [15:0] ADDR_NT_BASE     = 16'h2000;
	localparam logic [15:0] ADDR_MIRROR_BASE = 16'h3000;
	localparam logic [15:0] ADDR_PAL_BASE    = 16'h3F00;
	localparam logic [15:0] ADDR_PAL_END     = 16'h4000;

	localparam logic [8:0] SCAN_RESET  = 9'h1FF;
	localparam logic [8:0] SCAN_VBLANK = 9'd241;
	localparam logic [8:0] SCAN_LAST   = 9'd260;

	typedef enum logic [1:0] {
		RGN_NAME,
		RGN_PALETTE,
		RGN_EXT
	} region_t;

	typedef struct packed {
		region_t               region;
		logic [NT_IDX_W-1:0]   wr_nt;
		logic [PAL_IDX_W-1:0]  wr_pal;
		logic [15:0]           wr_addr;
		logic [NT_IDX_W-1:0]   rd_nt;
	} ptr_dec_t;

	// Bank select: vertical mirroring takes the low table bit, horizontal
	// mirroring maps the upper two tables onto the second bank.
	function automatic logic [NT_IDX_W-1:0] nt_index(input logic [15:0] ptr,
		input logic vert);
		logic [15:0] rel;
		logic [5:0]  tbl;
		logic        bank;
		rel  = ptr - ADDR_NT_BASE;
		tbl  = rel[15:10];
		bank = vert ? tbl[0] : (|tbl[5:1]);
		return {bank, ptr[9:0]};
	endfunction

	// Sprite backdrop entries fold onto the background backdrop entries.
	function automatic logic [PAL_IDX_W-1:0] pal_index(input logic [15:0] ptr);
		logic [PAL_IDX_W-1:0] e;
		e = ptr[PAL_IDX_W-1:0];
		if (e[4] && (e[1:0] == 2'b00)) begin
			e[4] = 1'b0;
		end
		return e;
	endfunction

endpackage

FILE: hdl/vrpva_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module vrpva_ram #(
	parameter int WIDTH = vrpva_pkg::DATA_W,
	parameter int DEPTH = vrpva_pkg::NAME_TABLE_BYTES
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/vrpva_addr.sv
// Decodes the VRAM pointer into the write region and RAM indexes.
module vrpva_addr (
	input  logic                 [15:0] ptr,
	input  logic                        mirror_vertical,
	output vrpva_pkg::ptr_dec_t         dec
);

	logic [15:0] wr_ptr;

	always_comb begin
		wr_ptr = ptr;
		// The upper name-table mirror drops bit 12 and acts as the base range.
		if (ptr >= vrpva_pkg::ADDR_MIRROR_BASE && ptr < vrpva_pkg::ADDR_PAL_BASE) begin
			wr_ptr[12] = 1'b0;
		end

		if (wr_ptr >= vrpva_pkg::ADDR_NT_BASE && wr_ptr < vrpva_pkg::ADDR_MIRROR_BASE) begin
			dec.region = vrpva_pkg::RGN_NAME;
		end else if (wr_ptr >= vrpva_pkg::ADDR_PAL_BASE && wr_ptr < vrpva_pkg::ADDR_PAL_END) begin
			dec.region = vrpva_pkg::RGN_PALETTE;
		end else begin
			dec.region = vrpva_pkg::RGN_EXT;
		end

		dec.wr_nt   = vrpva_pkg::nt_index(wr_ptr, mirror_vertical);
		dec.wr_pal  = vrpva_pkg::pal_index(wr_ptr);
		dec.wr_addr = wr_ptr;
		dec.rd_nt   = vrpva_pkg::nt_index(ptr, mirror_vertical);
	end

endmodule

FILE: hdl/video_register_port_vram_access.sv
// Top level of the CPU register port of the tile video processor.
// Usage: the block takes one request per clock, so busy stays low. Each
// accepted request gives exactly one result beat, marked by done, in the
// cycle right after acceptance; the receiver must take it then. Register
// updates, pointer moves and name-table or palette writes all land at the
// accepting edge, and a data-port read is served by the name-table RAM's
// registered read. The RAMs power up undefined and get no clearing pass.
module video_register_port_vram_access #(
	parameter int NAME_TABLE_BYTES = vrpva_pkg::NAME_TABLE_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [2:0]  reg_index,
	input  logic [7:0]  wdata,
	output logic        done,
	output logic [7:0]  rdata,
	output logic        nmi_pulse,
	output logic        ext_write,
	output logic [15:0] ext_addr,
	output logic [7:0]  ext_data
);

	`include "video_register_port_vram_access_macros.svh"

	localparam int NT_AW  = $clog2(NAME_TABLE_BYTES);
	localparam int PAL_AW = $clog2(vrpva_pkg::PALETTE_ENTRIES);

	logic        mirror_q;
	logic [7:0]  reg_q [8];
	logic [7:0]  reg_d [8];
	logic        toggle_q, toggle_d;
	logic [15:0] ptr_q, ptr_d;
	logic [8:0]  scan_q, scan_d;
	logic [8:0]  scan_inc;

	logic        done_q;
	logic        from_ram_q;
	logic [7:0]  rdata_q;
	logic        nmi_q;
	logic        extw_q;
	logic [15:0] exta_q;
	logic [7:0]  extd_q;

	logic        res_rdram;
	logic [7:0]  res_rdata;
	logic        res_nmi;
	logic        res_extw;
	logic [15:0] res_exta;
	logic [7:0]  res_extd;

	logic        accept;
	logic        cfg_wr;
	vrpva_pkg::req_t     req;
	vrpva_pkg::ptr_dec_t dec;

	logic             nt_we, nt_re, pal_we;
	logic [7:0]       nt_rdata;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign req    = vrpva_pkg::req_t'(req_type);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= 1'b0;
		end else if (cfg_wr && paddr[2] == vrpva_pkg::CFG_MIRROR) begin
			mirror_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == vrpva_pkg::CFG_MIRROR) ? {31'd0, mirror_q} : 32'd0;

	vrpva_addr u_addr (
		.ptr             (ptr_q),
		.mirror_vertical (mirror_q),
		.dec             (dec)
	);

	always_comb begin
		reg_d     = reg_q;
		toggle_d  = toggle_q;
		ptr_d     = ptr_q;
		scan_d    = scan_q;
		scan_inc  = scan_q + 9'd1;
		res_rdram = 1'b0;
		res_rdata = 8'd0;
		res_nmi   = 1'b0;
		res_extw  = 1'b0;
		res_exta  = 16'd0;
		res_extd  = 8'd0;
		nt_we     = 1'b0;
		nt_re     = 1'b0;
		pal_we    = 1'b0;
		if (accept) begin
			case (req)
				vrpva_pkg::REQ_REG_READ: begin
					res_rdata = reg_q[reg_index];
					// Reading status drops vblank and rearms the pointer load.
					if (reg_index == vrpva_pkg::REG_STATUS) begin
						reg_d[vrpva_pkg::REG_STATUS][7] = 1'b0;
						toggle_d = 1'b0;
					end
				end
				vrpva_pkg::REQ_REG_WRITE: begin
					reg_d[reg_index] = wdata;
					case (reg_index)
						vrpva_pkg::REG_SCROLL: begin
							toggle_d = !toggle_q;
						end
						vrpva_pkg::REG_ADDR: begin
							ptr_d    = toggle_q ? {ptr_q[15:8], wdata} : {wdata, ptr_q[7:0]};
							toggle_d = !toggle_q;
						end
						vrpva_pkg::REG_DATA: begin
							case (dec.region)
								vrpva_pkg::RGN_NAME: begin
									nt_we = 1'b1;
								end
								vrpva_pkg::RGN_PALETTE: begin
									pal_we = 1'b1;
								end
								default: begin
									res_extw = 1'b1;
									res_exta = dec.wr_addr;
									res_extd = wdata;
								end
							endcase
							ptr_d = ptr_q + (reg_q[vrpva_pkg::REG_CTRL][2] ?
								vrpva_pkg::PTR_STEP_ROW : vrpva_pkg::PTR_STEP_ONE);
						end
						default: begin
						end
					endcase
				end
				vrpva_pkg::REQ_DATA_READ: begin
					nt_re     = 1'b1;
					res_rdram = 1'b1;
					ptr_d     = ptr_q + vrpva_pkg::PTR_STEP_ONE;
				end
				default: begin
					scan_d = scan_inc;
					if (scan_inc == vrpva_pkg::SCAN_VBLANK) begin
						reg_d[vrpva_pkg::REG_STATUS][7] = 1'b1;
						res_nmi = reg_q[vrpva_pkg::REG_CTRL][7];
					end
					if (scan_inc == vrpva_pkg::SCAN_LAST) begin
						reg_d[vrpva_pkg::REG_STATUS][7:6] = 2'b00;
					end
					// An increment past the last scanline reloads the all-ones reset code.
					if (scan_inc > vrpva_pkg::SCAN_LAST) begin
						scan_d = vrpva_pkg::SCAN_RESET;
						reg_d[vrpva_pkg::REG_STATUS][5] = 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				reg_q[i] <= (i == int'(vrpva_pkg::REG_STATUS)) ?
					vrpva_pkg::STATUS_RESET : 8'd0;
			end
			toggle_q <= 1'b0;
			ptr_q    <= vrpva_pkg::PTR_RESET;
			scan_q   <= vrpva_pkg::SCAN_RESET;
			done_q   <= 1'b0;
		end else begin
			reg_q    <= reg_d;
			toggle_q <= toggle_d;
			ptr_q    <= ptr_d;
			scan_q   <= scan_d;
			done_q   <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			from_ram_q <= res_rdram;
			rdata_q    <= res_rdata;
			nmi_q      <= res_nmi;
			extw_q     <= res_extw;
			exta_q     <= res_exta;
			extd_q     <= res_extd;
		end
	end

	vrpva_ram #(
		.WIDTH (vrpva_pkg::DATA_W),
		.DEPTH (NAME_TABLE_BYTES)
	) u_nt_ram (
		.clk   (clk),
		.we    (nt_we),
		.waddr (NT_AW'(dec.wr_nt)),
		.wdata (wdata),
		.re    (nt_re),
		.raddr (NT_AW'(dec.rd_nt)),
		.rdata (nt_rdata)
	);

	// The palette is written through the data port only; no request reads it.
	vrpva_ram #(
		.WIDTH (vrpva_pkg::DATA_W),
		.DEPTH (vrpva_pkg::PALETTE_ENTRIES)
	) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (PAL_AW'(dec.wr_pal)),
		.wdata (wdata),
		.re    (1'b0),
		.raddr ({PAL_AW{1'b0}}),
		.rdata ()
	);

	assign done      = done_q;
	assign rdata     = from_ram_q ? nt_rdata : rdata_q;
	assign nmi_pulse = done_q && nmi_q;
	assign ext_write = done_q && extw_q;
	assign ext_addr  = done_q ? exta_q : 16'd0;
	assign ext_data  = done_q ? extd_q : 8'd0;

	`VRPVA_ASSERT_NEXT(a_beat_follows_accept, accept, done,
		"accepted request gave no result beat")
	`VRPVA_ASSERT_NOW(a_beat_has_request, done, $past(accept), "result beat without a request")
	`VRPVA_ASSERT_NOW(a_nmi_in_vblank, nmi_pulse, reg_q[vrpva_pkg::REG_STATUS][7],
		"NMI without vblank")
	`VRPVA_ASSERT_NOW(a_ext_excludes_read, ext_write, !from_ram_q && (rdata == 8'd0),
		"external write mixed with read data")
	`VRPVA_ASSERT_NOW(a_scan_range, 1'b1,
		(scan_q <= vrpva_pkg::SCAN_LAST) || (scan_q == vrpva_pkg::SCAN_RESET),
		"scanline counter out of range")

endmodule
